FILE: src/jdt_pkg.sv
// Package for the job dependency tracker: request and job state codes,
// defaults, field widths and the controller/datapath command and status structs.
// No dependencies.
package jdt_pkg;

   localparam int JOB_SLOTS_DEF  = 64;
   localparam int LINK_SLOTS_DEF = 64;

   localparam int IDX_W   = 6;
   localparam int GEN_W   = 32;
   localparam int PTR_W   = 7;
   localparam int LIM_W   = 7;
   localparam int CSR_W   = 1;
   localparam int REQ_W   = 3;
   localparam int JST_W   = 3;
   localparam int REQ_DW  = 80;
   localparam int RSP_DW  = 88;

   localparam logic [PTR_W-1:0] LINK_NONE = 7'h7F;

   localparam logic [REQ_W-1:0] REQ_CREATE   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ADD_DEP  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DISPATCH = 3'd2;
   localparam logic [REQ_W-1:0] REQ_COMPLETE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd4;
   localparam logic [REQ_W-1:0] REQ_RESET    = 3'd5;

   localparam logic [JST_W-1:0] ST_CREATED   = 3'd0;
   localparam logic [JST_W-1:0] ST_WAITING   = 3'd1;
   localparam logic [JST_W-1:0] ST_QUEUED    = 3'd2;
   localparam logic [JST_W-1:0] ST_RUNNING   = 3'd3;
   localparam logic [JST_W-1:0] ST_COMPLETED = 3'd4;

   localparam logic [CSR_W-1:0] CSR_JOB_LIMIT  = 1'b0;
   localparam logic [CSR_W-1:0] CSR_LINK_LIMIT = 1'b1;

   typedef struct packed {
      logic latch;
      logic look;
      logic exec;
      logic link_rd;
      logic tgt_rd;
      logic upd;
      logic final_emit;
   } cmd_type;

   typedef struct packed {
      logic walk_start;
      logic walk_more;
      logic upd_ready;
      logic buf_full;
      logic rsp_free;
   } sts_type;

endpackage

FILE: src/jdt_ctrl.sv
// Sequencer of the job dependency tracker: one request at a time, lookup,
// execute, dependent-list walk and result emission. Uses jdt_pkg.
module jdt_ctrl
   import jdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_LOOK  = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_LINK  = 7'b0001000,
      S_TGT   = 7'b0010000,
      S_UPD   = 7'b0100000,
      S_FINAL = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.walk_start ? S_LINK : S_FINAL;
         end
         S_LINK: begin
            if (sts.walk_more) begin
               cmd.link_rd = 1'b1;
               state_in    = S_TGT;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_TGT: begin
            cmd.tgt_rd = 1'b1;
            state_in   = S_UPD;
         end
         S_UPD: begin
            if (!(sts.upd_ready && sts.buf_full && !sts.rsp_free)) begin
               cmd.upd  = 1'b1;
               state_in = S_LINK;
            end
         end
         S_FINAL: begin
            if (sts.rsp_free) begin
               cmd.final_emit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && sts.upd_ready && sts.buf_full && !sts.rsp_free) |=>
         (state_ff == S_UPD))
      else $error("walk left update step while result was blocked");

   assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> (state_ff == S_LOOK) ##1 (state_ff == S_EXEC))
      else $error("lookup sequence broken");

   assert property (@(posedge clock) disable iff (reset)
      cmd.final_emit |=> req_ready)
      else $error("not idle after final result");

endmodule

FILE: src/jdt_datapath.sv
// Datapath of the job dependency tracker: job table and link pool memories,
// allocation counters, limit registers, result buffer and output register.
// Uses jdt_pkg; driven by jdt_ctrl.
module jdt_datapath
   import jdt_pkg::*;
#(
   parameter int JOB_SLOTS  = JOB_SLOTS_DEF,
   parameter int LINK_SLOTS = LINK_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [LIM_W-1:0]  csr_data,
   input  logic [REQ_W-1:0]  req_tuser,
   input  logic [REQ_DW-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,
   output logic              rsp_tlast,
   input  cmd_type           cmd,
   output sts_type           sts
);

   localparam int JOB_DEPTH  = (JOB_SLOTS < 64) ? JOB_SLOTS : 64;
   localparam int LINK_DEPTH = (LINK_SLOTS < 127) ? LINK_SLOTS : 127;
   localparam int JAW        = $clog2(JOB_DEPTH);
   localparam int LAW        = $clog2(LINK_DEPTH);
   localparam int STEP_W     = $clog2(LINK_SLOTS + 1);
   // only one epoch's jobs can be outstanding, since a reset needs none outstanding
   localparam int OST_W      = LIM_W + 1;

   // request
   logic [REQ_W-1:0] rq_type_ff;
   logic [IDX_W-1:0] rq_ji_ff, rq_pi_ff;
   logic [GEN_W-1:0] rq_jg_ff, rq_pg_ff;

   // limits and counters
   logic [LIM_W-1:0] job_lim_ff, link_lim_ff, job_cap, link_cap;
   logic [LIM_W-1:0] next_slot_ff, next_slot_in, next_link_ff, next_link_in;
   logic [OST_W-1:0] outst_ff, outst_in;
   logic [GEN_W-1:0] epoch_ff, epoch_in, epoch_inc;

   // memories
   logic [JST_W-1:0] st_mem   [JOB_DEPTH];
   logic [GEN_W-1:0] gen_mem  [JOB_DEPTH];
   logic [PTR_W-1:0] pend_mem [JOB_DEPTH];
   logic [PTR_W-1:0] head_mem [JOB_DEPTH];
   logic [IDX_W-1:0] lti_mem  [LINK_DEPTH];
   logic [GEN_W-1:0] ltg_mem  [LINK_DEPTH];
   logic [PTR_W-1:0] lsu_mem  [LINK_DEPTH];
   logic [JOB_DEPTH-1:0] jv_ff;

   logic [JAW-1:0]   addr_a, addr_b;
   logic [JST_W-1:0] st_a_q, st_b_q, st_a, st_b;
   logic [GEN_W-1:0] gen_a_q, gen_b_q, gen_a, gen_b;
   logic [PTR_W-1:0] pend_a_q, pend_a, head_a_q, head_b_q, head_a, head_b;
   logic             va_q, vb_q;
   logic [IDX_W-1:0] lti_q;
   logic [GEN_W-1:0] ltg_q;
   logic [PTR_W-1:0] lsu_q;

   logic             st_we, gen_we, pend_we, head_we, link_we, jv_set;
   logic [JAW-1:0]   st_wa, gen_wa, pend_wa, head_wa;
   logic [JST_W-1:0] st_wd;
   logic [PTR_W-1:0] pend_wd, head_wd;
   logic [LAW-1:0]   link_wa;

   // walk
   logic [PTR_W-1:0]  l_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [IDX_W-1:0]  tgt_ti_ff;
   logic [GEN_W-1:0]  tgt_tg_ff;

   // results
   logic             fail_ff, fail_in;
   logic [IDX_W-1:0] hidx_ff, hidx_in;
   logic [GEN_W-1:0] hgen_ff, hgen_in;
   logic [JST_W-1:0] jst_ff, jst_in;
   logic             buf_v_ff, buf_v_in;
   logic [IDX_W-1:0] buf_idx_ff, buf_idx_in;
   logic [GEN_W-1:0] buf_gen_ff, buf_gen_in;
   logic             rsp_v_ff, rsp_v_in, rsp_load, rsp_last_in, rsp_free;
   logic [RSP_DW-1:0] rsp_d_ff, rsp_d_in;
   logic             rsp_last_ff;

   logic va_ok, vb_ok, walk_start, upd_valid, upd_ready;

   always_comb begin
      job_cap = job_lim_ff;
      if (job_lim_ff == '0) job_cap = LIM_W'(1);
      else if (job_lim_ff > LIM_W'(JOB_DEPTH)) job_cap = LIM_W'(JOB_DEPTH);
      link_cap = link_lim_ff;
      if (link_lim_ff == '0) link_cap = LIM_W'(1);
      else if (link_lim_ff > LIM_W'(LINK_DEPTH)) link_cap = LIM_W'(LINK_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_lim_ff  <= LIM_W'(64);
         link_lim_ff <= LIM_W'(64);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_JOB_LIMIT:  job_lim_ff  <= csr_data;
            CSR_LINK_LIMIT: link_lim_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rq_type_ff <= req_tuser;
         rq_ji_ff   <= req_tdata[5:0];
         rq_jg_ff   <= req_tdata[37:6];
         rq_pi_ff   <= req_tdata[43:38];
         rq_pg_ff   <= req_tdata[75:44];
      end
   end

   // job table
   assign addr_a = cmd.tgt_rd ? lti_q[JAW-1:0] :
                   cmd.look   ? rq_ji_ff[JAW-1:0] : tgt_ti_ff[JAW-1:0];
   assign addr_b = rq_pi_ff[JAW-1:0];

   always_ff @(posedge clock) begin
      if (st_we)   st_mem[st_wa]     <= st_wd;
      if (gen_we)  gen_mem[gen_wa]   <= epoch_ff;
      if (pend_we) pend_mem[pend_wa] <= pend_wd;
      if (head_we) head_mem[head_wa] <= head_wd;
      st_a_q   <= st_mem[addr_a];
      st_b_q   <= st_mem[addr_b];
      gen_a_q  <= gen_mem[addr_a];
      gen_b_q  <= gen_mem[addr_b];
      pend_a_q <= pend_mem[addr_a];
      head_a_q <= head_mem[addr_a];
      head_b_q <= head_mem[addr_b];
      va_q     <= jv_ff[addr_a];
      vb_q     <= jv_ff[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset)       jv_ff <= '0;
      else if (jv_set) jv_ff[gen_wa] <= 1'b1;
   end

   assign st_a   = va_q ? st_a_q   : ST_COMPLETED;
   assign st_b   = vb_q ? st_b_q   : ST_COMPLETED;
   assign gen_a  = va_q ? gen_a_q  : '0;
   assign gen_b  = vb_q ? gen_b_q  : '0;
   assign pend_a = va_q ? pend_a_q : '0;
   assign head_a = va_q ? head_a_q : LINK_NONE;
   assign head_b = vb_q ? head_b_q : LINK_NONE;

   // link pool
   always_ff @(posedge clock) begin
      if (link_we) begin
         lti_mem[link_wa] <= rq_ji_ff;
         ltg_mem[link_wa] <= rq_jg_ff;
         lsu_mem[link_wa] <= head_b;
      end
      if (cmd.link_rd) begin
         lti_q <= lti_mem[l_ff[LAW-1:0]];
         ltg_q <= ltg_mem[l_ff[LAW-1:0]];
         lsu_q <= lsu_mem[l_ff[LAW-1:0]];
      end
   end

   assign va_ok = (rq_jg_ff != '0) && ({1'b0, rq_ji_ff} < job_cap) && (gen_a == rq_jg_ff);
   assign vb_ok = (rq_pg_ff != '0) && ({1'b0, rq_pi_ff} < job_cap) && (gen_b == rq_pg_ff);
   assign walk_start = (rq_type_ff == REQ_COMPLETE) && va_ok && (st_a == ST_QUEUED);
   assign upd_valid = (tgt_tg_ff != '0) && ({1'b0, tgt_ti_ff} < job_cap) &&
                      (gen_a == tgt_tg_ff);
   assign upd_ready = upd_valid && (pend_a == PTR_W'(1)) && (st_a == ST_WAITING);

   assign epoch_inc = epoch_ff + GEN_W'(1);

   always_comb begin
      st_we = 1'b0;  st_wa = rq_ji_ff[JAW-1:0];  st_wd = ST_CREATED;
      gen_we = 1'b0; gen_wa = next_slot_ff[JAW-1:0]; jv_set = 1'b0;
      pend_we = 1'b0; pend_wa = rq_ji_ff[JAW-1:0]; pend_wd = '0;
      head_we = 1'b0; head_wa = rq_pi_ff[JAW-1:0]; head_wd = LINK_NONE;
      link_we = 1'b0; link_wa = next_link_ff[LAW-1:0];
      next_slot_in = next_slot_ff;
      next_link_in = next_link_ff;
      outst_in = outst_ff;
      epoch_in = epoch_ff;
      fail_in = fail_ff; hidx_in = hidx_ff; hgen_in = hgen_ff; jst_in = jst_ff;
      buf_v_in = buf_v_ff; buf_idx_in = buf_idx_ff; buf_gen_in = buf_gen_ff;
      if (cmd.exec) begin
         fail_in = 1'b1; hidx_in = '0; hgen_in = '0; jst_in = '0; buf_v_in = 1'b0;
         case (rq_type_ff)
            REQ_CREATE: begin
               if (next_slot_ff < job_cap) begin
                  st_we = 1'b1; st_wa = next_slot_ff[JAW-1:0]; st_wd = ST_CREATED;
                  gen_we = 1'b1; jv_set = 1'b1;
                  pend_we = 1'b1; pend_wa = next_slot_ff[JAW-1:0]; pend_wd = '0;
                  head_we = 1'b1; head_wa = next_slot_ff[JAW-1:0]; head_wd = LINK_NONE;
                  next_slot_in = next_slot_ff + LIM_W'(1);
                  hidx_in = next_slot_ff[IDX_W-1:0];
                  hgen_in = epoch_ff;
                  fail_in = 1'b0;
               end
            end
            REQ_ADD_DEP: begin
               if (va_ok && vb_ok && st_a == ST_CREATED && st_b == ST_CREATED &&
                   next_link_ff < link_cap) begin
                  link_we = 1'b1;
                  head_we = 1'b1; head_wd = next_link_ff;
                  pend_we = 1'b1; pend_wd = pend_a + PTR_W'(1);
                  next_link_in = next_link_ff + LIM_W'(1);
                  fail_in = 1'b0;
               end
            end
            REQ_DISPATCH: begin
               if (va_ok) begin
                  if (st_a == ST_CREATED) begin
                     st_we = 1'b1;
                     st_wd = (pend_a == '0) ? ST_QUEUED : ST_WAITING;
                     outst_in = outst_ff + OST_W'(1);
                     buf_v_in = (pend_a == '0);
                     buf_idx_in = rq_ji_ff;
                     buf_gen_in = gen_a;
                     fail_in = 1'b0;
                  end else if (st_a inside {ST_WAITING, ST_QUEUED, ST_RUNNING}) begin
                     fail_in = 1'b0;
                  end
               end
            end
            REQ_COMPLETE: begin
               if (walk_start) begin
                  st_we = 1'b1; st_wd = ST_COMPLETED;
                  if (outst_ff != '0) outst_in = outst_ff - OST_W'(1);
                  fail_in = 1'b0;
               end
            end
            REQ_QUERY: begin
               if (va_ok) begin
                  jst_in = st_a;
                  fail_in = 1'b0;
               end
            end
            REQ_RESET: begin
               if (outst_ff == '0) begin
                  next_slot_in = '0;
                  next_link_in = '0;
                  epoch_in = (epoch_inc == '0) ? GEN_W'(1) : epoch_inc;
                  fail_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
      if (cmd.upd && upd_valid) begin
         pend_wa = tgt_ti_ff[JAW-1:0];
         st_wa = tgt_ti_ff[JAW-1:0];
         if (pend_a != '0) begin
            pend_we = 1'b1;
            pend_wd = pend_a - PTR_W'(1);
         end
         if (upd_ready) begin
            st_we = 1'b1; st_wd = ST_QUEUED;
            buf_v_in = 1'b1;
            buf_idx_in = tgt_ti_ff;
            buf_gen_in = gen_a;
         end
      end
      if (cmd.final_emit) buf_v_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff <= '0;
         next_link_ff <= '0;
         outst_ff     <= '0;
         epoch_ff     <= GEN_W'(1);
         buf_v_ff     <= 1'b0;
      end else begin
         next_slot_ff <= next_slot_in;
         next_link_ff <= next_link_in;
         outst_ff     <= outst_in;
         epoch_ff     <= epoch_in;
         buf_v_ff     <= buf_v_in;
      end
   end

   always_ff @(posedge clock) begin
      fail_ff    <= fail_in;
      hidx_ff    <= hidx_in;
      hgen_ff    <= hgen_in;
      jst_ff     <= jst_in;
      buf_idx_ff <= buf_idx_in;
      buf_gen_ff <= buf_gen_in;
      if (cmd.exec) begin
         l_ff     <= head_a;
         steps_ff <= '0;
      end else if (cmd.tgt_rd) begin
         l_ff      <= lsu_q;
         steps_ff  <= steps_ff + STEP_W'(1);
         tgt_ti_ff <= lti_q;
         tgt_tg_ff <= ltg_q;
      end
   end

   // output register
   assign rsp_free = !rsp_v_ff || rsp_tready;
   assign rsp_load = cmd.final_emit || (cmd.upd && upd_ready && buf_v_ff);
   assign rsp_last_in = cmd.final_emit;
   assign rsp_d_in = {7'd0,
                      buf_v_ff ? buf_gen_ff : GEN_W'(0),
                      buf_v_ff ? buf_idx_ff : IDX_W'(0),
                      buf_v_ff, jst_ff, hgen_ff, hidx_ff, fail_ff};
   assign rsp_v_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else       rsp_v_ff <= rsp_v_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_d_ff    <= rsp_d_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sts.walk_start = walk_start;
   assign sts.walk_more  = (l_ff < link_cap) && (steps_ff < STEP_W'(LINK_SLOTS));
   assign sts.upd_ready  = upd_ready;
   assign sts.buf_full   = buf_v_ff;
   assign sts.rsp_free   = rsp_free;

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      cmd.latch |-> !buf_v_ff)
      else $error("ready buffer left over from previous request");

   assert property (@(posedge clock) disable iff (reset)
      (next_slot_ff <= LIM_W'(JOB_DEPTH)) && (next_link_ff <= LIM_W'(LINK_DEPTH)))
      else $error("allocation counter beyond table");

endmodule

FILE: src/job_dependency_tracker.sv
// Top level of the job dependency tracker: stream ports, configuration port,
// controller and datapath. Uses jdt_pkg, jdt_ctrl and jdt_datapath.
//
// One request is handled at a time. Each request is latched, looked up in the
// job table and executed; create, add dependency, dispatch, query, reset,
// unknown request types and a failing complete then load their result word
// into the output register, after which the next request is taken. A successful
// complete first walks the dependency list: each link costs a link memory read,
// a job table read and an update, and the end of the list costs one more check.
// A request is held while the result side holds off and a word waits in the
// output register. A request that readies n jobs delivers n words, the last one
// marked by rsp_tlast; otherwise a single word. Configuration writes are taken
// in any cycle.
module job_dependency_tracker
   import jdt_pkg::*;
#(
   parameter int JOB_SLOTS  = JOB_SLOTS_DEF,
   parameter int LINK_SLOTS = LINK_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // req_type
   input  logic [REQ_W-1:0]  req_tuser,
   // job_index, job_gen, prereq_index, prereq_gen, zero pad
   input  logic [REQ_DW-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // status, handle_index, handle_gen, job_state_out, ready_valid,
   // ready_index, ready_gen, zero pad
   output logic [RSP_DW-1:0] rsp_tdata,
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [LIM_W-1:0]  csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   jdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   jdt_datapath #(
      .JOB_SLOTS  (JOB_SLOTS),
      .LINK_SLOTS (LINK_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

FILE: bench/tb_job_dependency_tracker.sv
// Testbench for job_dependency_tracker: directed and random request streams are
// checked word by word against an in-bench model of the job and link tables.
// Depends on jdt_pkg and the job_dependency_tracker RTL.
module tb_job_dependency_tracker;
   timeunit 1ns;
   timeprecision 1ps;
   import jdt_pkg::*;

   // request codes with no meaning
   localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

   typedef struct {
      logic        st;
      logic [5:0]  hidx;
      logic [31:0] hgen;
      logic [2:0]  jst;
      logic        rv;
      logic [5:0]  ridx;
      logic [31:0] rgen;
      logic        last;
   } rsp_word_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tuser;
   logic [REQ_DW-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index;
   logic [LIM_W-1:0]  csr_data;

   job_dependency_tracker u_dut (.*);

   // model of the job and link tables
   logic [2:0]  job_state [64];
   logic [31:0] job_gen_tab [64];
   logic [6:0]  job_pending [64];
   logic [6:0]  job_head [64];
   logic [5:0]  link_idx [64];
   logic [31:0] link_gen [64];
   logic [6:0]  link_next [64];
   int          alloc_job;
   int          alloc_link;
   int          jobs_open;
   logic [31:0] cur_epoch;
   logic [6:0]  job_limit_reg;
   logic [6:0]  link_limit_reg;

   rsp_word_type words_due[$];
   int          errors = 0;
   int          items_sent = 0;
   int          hold_cycles = 0;
   bit          tx_idle_on = 1;
   bit          rx_idle_on = 1;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int job_cap();
      int v = job_limit_reg;
      if (v < 1) v = 1;
      if (v > 64) v = 64;
      return v;
   endfunction

   function automatic int link_cap();
      int v = link_limit_reg;
      if (v < 1) v = 1;
      if (v > 64) v = 64;
      return v;
   endfunction

   function automatic bit handle_ok(logic [5:0] idx, logic [31:0] gen);
      return gen != 0 && idx < job_cap() && job_gen_tab[idx] == gen;
   endfunction

   task automatic track_request(input logic [2:0] t, input logic [5:0] idx,
                                input logic [31:0] gen, input logic [5:0] pidx,
                                input logic [31:0] pgen, output logic [5:0] new_idx,
                                output logic [31:0] new_gen, output bit ok);
      int        woken[$];
      logic      fail;
      logic [2:0] jst;
      int        l, steps, s;
      logic [5:0] ti;
      logic [6:0] prev;
      rsp_word_type w;
      fail = 1;
      jst = 0;
      new_idx = 0;
      new_gen = 0;
      case (t)
         REQ_CREATE: begin
            if (alloc_job < job_cap()) begin
               s = alloc_job++;
               job_gen_tab[s] = cur_epoch;
               job_pending[s] = 0;
               job_head[s] = LINK_NONE;
               job_state[s] = ST_CREATED;
               new_idx = 6'(s);
               new_gen = cur_epoch;
               fail = 0;
            end
         end
         REQ_ADD_DEP: begin
            if (handle_ok(idx, gen) && handle_ok(pidx, pgen) &&
                job_state[idx] == ST_CREATED && job_state[pidx] == ST_CREATED &&
                alloc_link < link_cap()) begin
               l = alloc_link++;
               link_idx[l] = idx;
               link_gen[l] = gen;
               link_next[l] = job_head[pidx];
               job_head[pidx] = 7'(l);
               job_pending[idx]++;
               fail = 0;
            end
         end
         REQ_DISPATCH: begin
            if (handle_ok(idx, gen)) begin
               if (job_state[idx] == ST_CREATED) begin
                  job_state[idx] = ST_WAITING;
                  jobs_open++;
                  if (job_pending[idx] == 0) begin
                     job_state[idx] = ST_QUEUED;
                     woken.push_back(int'(idx));
                  end
                  fail = 0;
               end else if (job_state[idx] != ST_COMPLETED) begin
                  fail = 0;
               end
            end
         end
         REQ_COMPLETE: begin
            if (handle_ok(idx, gen) && job_state[idx] == ST_QUEUED) begin
               job_state[idx] = ST_COMPLETED;
               l = int'(job_head[idx]);
               steps = 0;
               while (l < link_cap() && steps < 64) begin
                  ti = link_idx[l];
                  if (handle_ok(ti, link_gen[l])) begin
                     prev = job_pending[ti];
                     if (prev != 0) job_pending[ti] = prev - 7'd1;
                     if (prev == 1 && job_state[ti] == ST_WAITING) begin
                        job_state[ti] = ST_QUEUED;
                        woken.push_back(int'(ti));
                     end
                  end
                  l = int'(link_next[l]);
                  steps++;
               end
               if (jobs_open != 0) jobs_open--;
               fail = 0;
            end
         end
         REQ_QUERY: begin
            if (handle_ok(idx, gen)) begin
               jst = job_state[idx];
               fail = 0;
            end
         end
         REQ_RESET: begin
            if (jobs_open == 0) begin
               alloc_job = 0;
               alloc_link = 0;
               cur_epoch = cur_epoch + 32'd1;
               if (cur_epoch == 0) cur_epoch = 1;
               fail = 0;
            end
         end
         default: ;
      endcase
      w = '{fail, new_idx, new_gen, jst, 1'b0, 6'd0, 32'd0, 1'b1};
      if (woken.size() == 0) words_due.push_back(w);
      foreach (woken[k]) begin
         w.rv = 1;
         w.ridx = 6'(woken[k]);
         w.rgen = job_gen_tab[woken[k]];
         w.last = (k == woken.size() - 1);
         words_due.push_back(w);
      end
      ok = !fail;
   endtask

   task automatic send_req(input logic [2:0] t, input logic [5:0] idx,
                           input logic [31:0] gen, input logic [5:0] pidx,
                           input logic [31:0] pgen, output logic [5:0] new_idx,
                           output logic [31:0] new_gen, output bit ok);
      int gap;
      track_request(t, idx, gen, pidx, pgen, new_idx, new_gen, ok);
      gap = tx_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = t;
      req_tdata = {4'b0, pgen, pidx, gen, idx};
      req_tvalid = 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 0;
      items_sent++;
   endtask

   // request without interest in the outcome
   task automatic fire(input logic [2:0] t, input logic [5:0] idx, input logic [31:0] gen,
                       input logic [5:0] pidx = 0, input logic [31:0] pgen = 0);
      logic [5:0]  hi;
      logic [31:0] hg;
      bit          ok;
      send_req(t, idx, gen, pidx, pgen, hi, hg, ok);
   endtask

   task automatic write_csr(input logic [CSR_W-1:0] idx, input logic [LIM_W-1:0] val);
      csr_index = idx;
      csr_data = val;
      csr_valid = 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
      if (idx == CSR_JOB_LIMIT) job_limit_reg = val;
      else link_limit_reg = val;
   endtask

   task automatic drain_words();
      while (words_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // small DAG: edges only from earlier to later jobs, so every job drains
   task automatic run_graph(input int n, input int edge_pct);
      logic [5:0]  hi [8];
      logic [31:0] hg [8];
      bit          okv [8];
      int          order[$];
      bit          progress;
      fire(REQ_RESET, 6'($urandom), $urandom, 6'($urandom), $urandom);
      for (int k = 0; k < n; k++) begin
         send_req(REQ_CREATE, 6'($urandom), $urandom, 6'($urandom), $urandom,
                  hi[k], hg[k], okv[k]);
         order.push_back(k);
      end
      for (int j = 1; j < n; j++)
         for (int i = 0; i < j; i++)
            if (okv[i] && okv[j] && $urandom_range(0, 99) < edge_pct)
               fire(REQ_ADD_DEP, hi[j], hg[j], hi[i], hg[i]);
      order.shuffle();
      foreach (order[k]) begin
         if (okv[order[k]])
            fire(REQ_DISPATCH, hi[order[k]], hg[order[k]], 6'($urandom), $urandom);
         if ($urandom_range(0, 3) == 0)
            fire(REQ_QUERY, hi[order[k]], hg[order[k]], 6'($urandom), $urandom);
      end
      progress = 1;
      while (progress) begin
         progress = 0;
         for (int k = 0; k < n; k++) begin
            if (okv[k] && job_state[hi[k]] == ST_QUEUED && job_gen_tab[hi[k]] == hg[k]) begin
               fire(REQ_COMPLETE, hi[k], hg[k], 6'($urandom), $urandom);
               progress = 1;
            end
         end
      end
   endtask

   task automatic test_directed();
      logic [5:0]  ai, bi, ci, di, ei, fi;
      logic [31:0] ag, bg, cg, dg, eg, fg;
      bit          ok;
      send_req(REQ_CREATE, 0, 0, 0, 0, ai, ag, ok);
      fire(REQ_QUERY, ai, ag);
      send_req(REQ_CREATE, 6'h3F, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, bi, bg, ok);
      send_req(REQ_CREATE, 0, 0, 0, 0, ci, cg, ok);
      fire(REQ_ADD_DEP, bi, bg, ai, ag);
      fire(REQ_ADD_DEP, ci, cg, ci, cg);   // self dependency, never dispatched
      fire(REQ_DISPATCH, bi, bg);
      fire(REQ_DISPATCH, ai, ag);
      fire(REQ_DISPATCH, ai, ag);          // already queued: no effect
      fire(REQ_ADD_DEP, ai, ag, ci, cg);   // job not in created state
      fire(REQ_RESET, 0, 0);               // jobs outstanding: fails
      fire(REQ_COMPLETE, bi, bg);          // still waiting
      fire(REQ_COMPLETE, ai, ag);
      fire(REQ_COMPLETE, bi, bg);
      fire(REQ_COMPLETE, ai, ag);          // already done
      fire(REQ_DISPATCH, ai, ag);          // completed job
      fire(REQ_QUERY, ai, 32'd0);          // generation zero
      fire(REQ_QUERY, 6'h3F, 32'hFFFF_FFFF);
      fire(REQ_UNDEF_LO, ai, ag);
      fire(REQ_UNDEF_HI, 6'h3F, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
      send_req(REQ_CREATE, 0, 0, 0, 0, di, dg, ok);
      send_req(REQ_CREATE, 0, 0, 0, 0, ei, eg, ok);
      send_req(REQ_CREATE, 0, 0, 0, 0, fi, fg, ok);
      fire(REQ_ADD_DEP, ei, eg, di, dg);
      fire(REQ_ADD_DEP, fi, fg, di, dg);
      fire(REQ_DISPATCH, ei, eg);
      fire(REQ_DISPATCH, fi, fg);
      fire(REQ_DISPATCH, di, dg);
      fire(REQ_COMPLETE, di, dg);          // readies two jobs
      fire(REQ_COMPLETE, ei, eg);
      fire(REQ_COMPLETE, fi, fg);
      fire(REQ_RESET, 0, 0);
      fire(REQ_QUERY, ai, ag);             // old handle, slot not reused yet
      drain_words();
   endtask

   task automatic test_limits();
      logic [5:0]  hi;
      logic [31:0] hg;
      bit          ok;
      write_csr(CSR_JOB_LIMIT, 7'd1);
      fire(REQ_RESET, 0, 0);
      fire(REQ_CREATE, 0, 0);
      fire(REQ_CREATE, 0, 0);
      drain_words();
      write_csr(CSR_JOB_LIMIT, 7'd0);
      fire(REQ_RESET, 0, 0);
      fire(REQ_CREATE, 0, 0);
      fire(REQ_CREATE, 0, 0);
      drain_words();
      write_csr(CSR_JOB_LIMIT, 7'd127);
      write_csr(CSR_LINK_LIMIT, 7'd1);
      run_graph(3, 100);
      drain_words();
      write_csr(CSR_LINK_LIMIT, 7'd0);
      run_graph(3, 100);
      drain_words();
      write_csr(CSR_LINK_LIMIT, 7'd64);
      write_csr(CSR_JOB_LIMIT, 7'd64);
      fire(REQ_RESET, 0, 0);
      tx_idle_on = 0;
      for (int k = 0; k < 65; k++) send_req(REQ_CREATE, 0, 0, 0, 0, hi, hg, ok);
      tx_idle_on = 1;
      fire(REQ_QUERY, 6'd63, cur_epoch);
      drain_words();
      write_csr(CSR_LINK_LIMIT, 7'd127);
      write_csr(CSR_JOB_LIMIT, 7'd2);
      fire(REQ_QUERY, 6'd63, cur_epoch);   // beyond the job limit
      drain_words();
      write_csr(CSR_JOB_LIMIT, 7'd64);
   endtask

   task automatic test_random_graphs();
      int stop_at;
      stop_at = items_sent + 5;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 5) == 0) begin
            drain_words();
            write_csr(CSR_JOB_LIMIT,
                      LIM_W'($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 64));
            write_csr(CSR_LINK_LIMIT,
                      LIM_W'($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 64));
         end
         tx_idle_on = $urandom_range(0, 3) != 0;
         rx_idle_on = $urandom_range(0, 3) != 0;
         run_graph($urandom_range(1, 8), $urandom_range(10, 70));
      end
      tx_idle_on = 1;
      rx_idle_on = 1;
      drain_words();
      write_csr(CSR_JOB_LIMIT, 7'd64);
      write_csr(CSR_LINK_LIMIT, 7'd64);
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      tx_idle_on = 0;
      run_graph(6, 40);
      tx_idle_on = 1;
      drain_words();
   endtask

   // random words of every kind; may strand jobs, so it runs last
   task automatic test_noise();
      logic [5:0]  idx;
      logic [31:0] gen;
      for (int k = 0; k < 8; k++) begin
         idx = 6'($urandom_range(0, 7));
         gen = $urandom_range(0, 1) ? job_gen_tab[idx] : $urandom;
         if ($urandom_range(0, 1)) idx = 6'($urandom);
         fire(3'($urandom_range(0, 7)), idx, gen, 6'($urandom), $urandom);
      end
   endtask

   // response side
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         if (rx_idle_on) begin
            rsp_tready = 0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end
         rsp_tready = 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic report(input string f, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, f, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            w = words_due.pop_front();
            report("status", 32'(w.st), 32'(rsp_tdata[0]));
            report("handle_index", 32'(w.hidx), 32'(rsp_tdata[6:1]));
            report("handle_gen", w.hgen, rsp_tdata[38:7]);
            report("job_state", 32'(w.jst), 32'(rsp_tdata[41:39]));
            report("ready_valid", 32'(w.rv), 32'(rsp_tdata[42]));
            report("ready_index", 32'(w.ridx), 32'(rsp_tdata[48:43]));
            report("ready_gen", w.rgen, rsp_tdata[80:49]);
            report("last", 32'(w.last), 32'(rsp_tlast));
         end
      end
   end

   initial begin
      for (int k = 0; k < 64; k++) begin
         job_state[k] = ST_COMPLETED;
         job_gen_tab[k] = 0;
         job_pending[k] = 0;
         job_head[k] = LINK_NONE;
         link_idx[k] = 0;
         link_gen[k] = 0;
         link_next[k] = 0;
      end
      alloc_job = 0;
      alloc_link = 0;
      jobs_open = 0;
      cur_epoch = 1;
      job_limit_reg = 64;
      link_limit_reg = 64;
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = 0;
      csr_valid = 0;
      csr_index = CSR_JOB_LIMIT;
      csr_data = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_limits();
      test_random_graphs();
      test_backpressure();
      test_noise();
      req_tvalid = 0;
      drain_words();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
